FILE: hw/rtl/cnad_pkg.sv
// shared constants, types and the reciprocal table of the neighbour average demosaic
// no dependencies; used by cnad_chan and cfa_neighbour_average_demosaic_top
`default_nettype none

package cnad_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 3;

  localparam int DIM_BITS    = 13;
  localparam int CODE_BITS   = 2;
  localparam int NB_COUNT    = 8;
  localparam int CNT_BITS    = 4;
  localparam int SUM_BITS    = SAMPLE_BITS + 3;
  localparam int OUT_BITS    = SAMPLE_BITS + FRAC_BITS;
  localparam int NUM_BITS    = SUM_BITS + FRAC_BITS + 2;
  localparam int RECIP_SHIFT = NUM_BITS;
  localparam int RECIP_BITS  = NUM_BITS;
  localparam int DIV_BITS    = CNT_BITS + 1;
  localparam int REM_BITS    = DIV_BITS + 1;
  localparam int REG_IDX_BITS = 3;

  localparam int IN_BITS     = 2 * COORD_BITS + 9 * SAMPLE_BITS;
  localparam int IN_BYTES_BITS  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BYTES_BITS = ((3 * OUT_BITS + 7) / 8) * 8;

  // channel codes
  localparam logic [CODE_BITS-1:0] CH_RED   = 2'd0;
  localparam logic [CODE_BITS-1:0] CH_GREEN = 2'd1;
  localparam logic [CODE_BITS-1:0] CH_BLUE  = 2'd2;

  // register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_CFA_EE       = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_CFA_EO       = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_CFA_OE       = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_CFA_OO       = 3'd5;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  // neighbours: nw, n, ne, w, e, sw, s, se
  typedef sample_t [NB_COUNT-1:0] nbrs_t;

  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
  } pipe_ctrl_t;

  // floor(2^RECIP_SHIFT / (2 * count)) for the averaging divide
  localparam logic [RECIP_SHIFT:0] RECIP_ONE = (RECIP_SHIFT + 1)'(1) << RECIP_SHIFT;
  localparam logic [RECIP_BITS-1:0] RECIP_C1 = RECIP_BITS'(RECIP_ONE / 2);
  localparam logic [RECIP_BITS-1:0] RECIP_C2 = RECIP_BITS'(RECIP_ONE / 4);
  localparam logic [RECIP_BITS-1:0] RECIP_C3 = RECIP_BITS'(RECIP_ONE / 6);
  localparam logic [RECIP_BITS-1:0] RECIP_C4 = RECIP_BITS'(RECIP_ONE / 8);
  localparam logic [RECIP_BITS-1:0] RECIP_C5 = RECIP_BITS'(RECIP_ONE / 10);
  localparam logic [RECIP_BITS-1:0] RECIP_C6 = RECIP_BITS'(RECIP_ONE / 12);
  localparam logic [RECIP_BITS-1:0] RECIP_C7 = RECIP_BITS'(RECIP_ONE / 14);
  localparam logic [RECIP_BITS-1:0] RECIP_C8 = RECIP_BITS'(RECIP_ONE / 16);

  function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] count);
    logic [RECIP_BITS-1:0] r;
    unique case (count)
      4'd1:    r = RECIP_C1;
      4'd2:    r = RECIP_C2;
      4'd3:    r = RECIP_C3;
      4'd4:    r = RECIP_C4;
      4'd5:    r = RECIP_C5;
      4'd6:    r = RECIP_C6;
      4'd7:    r = RECIP_C7;
      4'd8:    r = RECIP_C8;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cfa_neighbour_average_demosaic_top.sv
// top level of the 3x3 neighbour average demosaic: handshake, registers, frame masks
// depends on cnad_pkg and cnad_chan
`default_nettype none

// channel      direction  handshake                   payload
// s_axis       in         tvalid / tready             tdata: pos_x, pos_y, 3x3 window
// m_axis       out        tvalid / tready             tdata: red, green, blue
// cfg          in         cfg_wr_en, no wait          cfg_index, cfg_data
//
// four register stages: frame and pattern masks, masked sum and count,
// reciprocal multiply, rounding fix-up into the output register
// one transaction is taken every cycle unless a stalled output has backed up the stages
// each stage advances when it is empty or the stage after it advances, so a
// stalled output keeps taking input until the bubbles are filled
// synchronous reset clears valid bits and restores the register defaults;
// input ready is held low while reset is high

module cfa_neighbour_average_demosaic_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // pos_x, pos_y, s_nw, s_n, s_ne, s_w, s_c, s_e, s_sw, s_s, s_se
  input  wire logic [cnad_pkg::IN_BYTES_BITS-1:0]    s_axis_tdata,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // red, green, blue, zero pad
  output logic [cnad_pkg::OUT_BYTES_BITS-1:0]        m_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [cnad_pkg::REG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [cnad_pkg::DIM_BITS-1:0]         cfg_data
);
  import cnad_pkg::*;

  // configuration registers
  logic [DIM_BITS-1:0]                frame_width;
  logic [DIM_BITS-1:0]                frame_height;
  logic [3:0][CODE_BITS-1:0]          cfa_code;   // index: row parity, column parity

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_BITS'(1920);
      frame_height <= DIM_BITS'(1080);
      cfa_code[0]  <= CH_RED;
      cfa_code[1]  <= CH_GREEN;
      cfa_code[2]  <= CH_GREEN;
      cfa_code[3]  <= CH_BLUE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_CFA_EE:       cfa_code[0]  <= cfg_data[CODE_BITS-1:0];
        REG_CFA_EO:       cfa_code[1]  <= cfg_data[CODE_BITS-1:0];
        REG_CFA_OE:       cfa_code[2]  <= cfg_data[CODE_BITS-1:0];
        REG_CFA_OO:       cfa_code[3]  <= cfg_data[CODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input unpacking
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  sample_t               s_c;
  nbrs_t                 nbrs_in;

  always_comb begin
    pos_x = s_axis_tdata[0 +: COORD_BITS];
    pos_y = s_axis_tdata[COORD_BITS +: COORD_BITS];
    // window order nw n ne w c e sw s se after the coordinates
    for (int i = 0; i < 4; i++) begin
      nbrs_in[i] = s_axis_tdata[2*COORD_BITS + i*SAMPLE_BITS +: SAMPLE_BITS];
    end
    s_c = s_axis_tdata[2*COORD_BITS + 4*SAMPLE_BITS +: SAMPLE_BITS];
    for (int i = 4; i < NB_COUNT; i++) begin
      nbrs_in[i] = s_axis_tdata[2*COORD_BITS + (i+1)*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  // pipeline control: valid bits and per-stage advance
  logic v1, v2, v3;
  logic en1, en4;
  pipe_ctrl_t ctrl;

  always_comb begin
    en4      = !m_axis_tvalid || m_axis_tready;
    ctrl.en4 = en4;
    ctrl.en3 = !v3 || en4;
    ctrl.en2 = !v2 || ctrl.en3;
    en1      = !v1 || ctrl.en2;
  end

  // no transaction is taken while reset is high
  assign s_axis_tready = en1 && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (en1)      v1            <= s_axis_tvalid;
      if (ctrl.en2) v2            <= v1;
      if (ctrl.en3) v3            <= v2;
      if (en4)      m_axis_tvalid <= v3;
    end
  end

  // stage 1: which neighbours are in frame and carry each channel, and which channel the centre carries
  logic [DIM_BITS:0]       x_ext, y_ext, w_ext, h_ext;
  logic [2:0]              col_ok, row_ok;   // offset -1, 0, +1
  logic [2:0]              col_par, row_par;
  logic [2:0][NB_COUNT-1:0] mask_next;
  logic [2:0]              pass_next;
  logic [CODE_BITS-1:0]    nb_code;
  logic [CODE_BITS-1:0]    c_code;
  int                      dxi, dyi;

  always_comb begin
    x_ext = (DIM_BITS + 1)'(pos_x);
    y_ext = (DIM_BITS + 1)'(pos_y);
    w_ext = (DIM_BITS + 1)'(frame_width);
    h_ext = (DIM_BITS + 1)'(frame_height);
    col_ok[0] = (pos_x != '0) && (x_ext <= w_ext);
    col_ok[1] = x_ext < w_ext;
    col_ok[2] = (x_ext + (DIM_BITS + 1)'(1)) < w_ext;
    row_ok[0] = (pos_y != '0) && (y_ext <= h_ext);
    row_ok[1] = y_ext < h_ext;
    row_ok[2] = (y_ext + (DIM_BITS + 1)'(1)) < h_ext;
    col_par   = {~pos_x[0], pos_x[0], ~pos_x[0]};
    row_par   = {~pos_y[0], pos_y[0], ~pos_y[0]};
    c_code    = cfa_code[{pos_y[0], pos_x[0]}];
    mask_next = '0;
    nb_code   = '0;
    dxi       = 0;
    dyi       = 0;
    for (int i = 0; i < NB_COUNT; i++) begin
      // neighbour slot to window offset, centre skipped
      dyi = (i < 3) ? 0 : ((i < 5) ? 1 : 2);
      dxi = (i < 3) ? i : ((i < 5) ? ((i == 3) ? 0 : 2) : (i - 5));
      nb_code = cfa_code[{row_par[dyi], col_par[dxi]}];
      for (int ch = 0; ch < 3; ch++) begin
        mask_next[ch][i] = col_ok[dxi] && row_ok[dyi] && (nb_code == CODE_BITS'(ch));
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      pass_next[ch] = c_code == CODE_BITS'(ch);
    end
  end

  logic [2:0][NB_COUNT-1:0] mask1;
  logic [2:0]               pass1;
  nbrs_t                    nbrs1;
  sample_t                  centre1;

  always_ff @(posedge clk) begin
    if (en1) begin
      mask1   <= mask_next;
      pass1   <= pass_next;
      nbrs1   <= nbrs_in;
      centre1 <= s_c;
    end
  end

  // stages 2 to 4, one unit per channel
  logic [2:0][OUT_BITS-1:0] rgb;

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    cnad_chan u_chan (
      .clk    (clk),
      .ctrl   (ctrl),
      .mask   (mask1[ch]),
      .pass   (pass1[ch]),
      .nbrs   (nbrs1),
      .centre (centre1),
      .result (rgb[ch])
    );
  end

  assign m_axis_tdata = OUT_BYTES_BITS'(rgb);

endmodule

`default_nettype wire

FILE: hw/rtl/cnad_chan.sv
// one colour channel: masked neighbour sum, reciprocal multiply, rounding fix-up
// depends on cnad_pkg; stage enables come from the top level
`default_nettype none

module cnad_chan (
  input  wire logic                              clk,
  input  wire cnad_pkg::pipe_ctrl_t              ctrl,
  input  wire logic [cnad_pkg::NB_COUNT-1:0]     mask,
  input  wire logic                              pass,
  input  wire cnad_pkg::nbrs_t                   nbrs,
  input  wire cnad_pkg::sample_t                 centre,
  output logic [cnad_pkg::OUT_BITS-1:0]          result
);
  import cnad_pkg::*;

  // stage 2
  logic [SUM_BITS-1:0]    sum2;
  logic [SUM_BITS-1:0]    sum2_next;
  logic [CNT_BITS-1:0]    cnt2;
  logic                   pass2;
  sample_t                centre2;

  // stage 3
  logic [NUM_BITS+RECIP_BITS-1:0] prod3;
  logic [NUM_BITS-1:0]    num3;
  logic [NUM_BITS-1:0]    num2;
  logic [CNT_BITS-1:0]    cnt3;
  logic                   pass3;
  sample_t                centre3;

  // stage 4 logic
  logic [OUT_BITS-1:0]          q_est;
  logic [DIV_BITS-1:0]          divisor;
  logic [OUT_BITS+DIV_BITS-1:0] qd;
  logic [REM_BITS-1:0]          rem;
  logic [OUT_BITS-1:0]          result_next;

  always_comb begin
    sum2_next = '0;
    for (int i = 0; i < NB_COUNT; i++) begin
      if (mask[i]) begin
        sum2_next = sum2_next + SUM_BITS'(nbrs[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      sum2    <= sum2_next;
      cnt2    <= CNT_BITS'($countones(mask));
      pass2   <= pass;
      centre2 <= centre;
    end
  end

  // numerator of the round-half-up divide: sum * 2^(frac+1) + count
  assign num2 = (NUM_BITS'(sum2) << (FRAC_BITS + 1)) + NUM_BITS'(cnt2);

  always_ff @(posedge clk) begin
    if (ctrl.en3) begin
      prod3   <= (NUM_BITS + RECIP_BITS)'(num2) * (NUM_BITS + RECIP_BITS)'(recip(cnt2));
      num3    <= num2;
      cnt3    <= cnt2;
      pass3   <= pass2;
      centre3 <= centre2;
    end
  end

  // estimate is exact or one low; one compare fixes it
  always_comb begin
    q_est   = prod3[RECIP_SHIFT +: OUT_BITS];
    divisor = {cnt3, 1'b0};
    qd      = (OUT_BITS + DIV_BITS)'(q_est) * (OUT_BITS + DIV_BITS)'(divisor);
    rem     = num3[REM_BITS-1:0] - qd[REM_BITS-1:0];
    if (pass3) begin
      result_next = OUT_BITS'(centre3) << FRAC_BITS;
    end else if (cnt3 == '0) begin
      result_next = '0;
    end else if (rem >= REM_BITS'(divisor)) begin
      result_next = q_est + OUT_BITS'(1);
    end else begin
      result_next = q_est;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en4) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for cfa_neighbour_average_demosaic_top: a directed table, then random
// pixels under several filter patterns and frame sizes, with idling and a long output stall
// depends on cnad_pkg and the rtl top level

module tb_top;
  import cnad_pkg::*;

  // code three: the site carries no channel
  localparam logic [CODE_BITS-1:0]    CH_NONE      = 2'd3;
  // indexes past the last register, expected to be ignored
  localparam logic [REG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int STALL_LIMIT = 3000;  // cycles without any transaction
  localparam int HOLD_CYCLES = 300;   // long output hold-off
  localparam int PHASE_ITEMS = 85;
  localparam int NUM_PHASES  = 8;
  localparam int TAIL_CYCLES = 8;     // pipeline is four deep

  // tdata of the input, lowest field first at the bottom
  typedef struct packed {
    sample_t               s_se, s_s, s_sw, s_e, s_c, s_w, s_ne, s_n, s_nw;
    logic [COORD_BITS-1:0] pos_y, pos_x;
  } pixel_t;

  typedef struct packed {
    logic [OUT_BYTES_BITS-3*OUT_BITS-1:0] pad;
    logic [OUT_BITS-1:0]                  blue, green, red;
  } rgb_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]             width, height;
    logic [3:0][CODE_BITS-1:0]       pattern;  // row parity * 2 + column parity
  } setup_t;

  typedef struct {
    logic   reconf;
    setup_t setup;
    pixel_t pix;
    logic   typed;
    rgb_t   want;
  } row_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic [IN_BYTES_BITS-1:0]      s_axis_tdata;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [OUT_BYTES_BITS-1:0]     m_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic                          cfg_wr_en;
  logic [REG_IDX_BITS-1:0]       cfg_index;
  logic [DIM_BITS-1:0]           cfg_data;

  setup_t active;           // register contents as the block holds them
  rgb_t   next_want;        // expectation for the transaction now offered
  rgb_t   rgb_expected[$];
  row_t   stim_rows[$];
  logic   in_took = 1'b0;
  int     quiet_cycles = 0;
  int     fail_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  logic   hold_armed = 1'b0;

  cfa_neighbour_average_demosaic_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bilinear estimate of red, green and blue for one window
  function automatic rgb_t demosaic_rgb(input pixel_t p, input setup_t c);
    sample_t             win [9];
    logic [OUT_BITS-1:0] chan [3];
    int                  x, y, nx, ny;
    longint unsigned     sum, count;
    rgb_t                r;
    win = '{p.s_nw, p.s_n, p.s_ne, p.s_w, p.s_c, p.s_e, p.s_sw, p.s_s, p.s_se};
    x = int'(p.pos_x);
    y = int'(p.pos_y);
    for (int ch = 0; ch < 3; ch++) begin
      if (c.pattern[{y[0], x[0]}] == CODE_BITS'(ch)) begin
        chan[ch] = OUT_BITS'(p.s_c) << FRAC_BITS;
      end else begin
        sum = 0;
        count = 0;
        // only neighbours are bounded by the frame, never the centre
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            nx = x + dx;
            ny = y + dy;
            if ((dx != 0 || dy != 0) && nx >= 0 && nx < int'(c.width) &&
                ny >= 0 && ny < int'(c.height) &&
                c.pattern[{ny[0], nx[0]}] == CODE_BITS'(ch)) begin
              sum += win[(dy + 1) * 3 + dx + 1];
              count++;
            end
          end
        end
        // round half up on FRAC_BITS fraction bits
        chan[ch] = (count == 0) ? '0 :
                   OUT_BITS'(((sum << (FRAC_BITS + 1)) + count) / (count << 1));
      end
    end
    r = '0;
    r.red   = chan[0];
    r.green = chan[1];
    r.blue  = chan[2];
    return r;
  endfunction

  function automatic setup_t make_setup(input int w, input int h,
                                        input logic [CODE_BITS-1:0] ee, eo, oe, oo);
    setup_t c;
    c.width   = DIM_BITS'(w);
    c.height  = DIM_BITS'(h);
    c.pattern = {oo, oe, eo, ee};
    return c;
  endfunction

  function automatic pixel_t make_pixel(input int x, input int y,
                                        input sample_t nw, n, ne, w, ctr, e, sw, s, se);
    pixel_t p;
    p = '{se, s, sw, e, ctr, w, ne, n, nw, COORD_BITS'(y), COORD_BITS'(x)};
    return p;
  endfunction

  function automatic rgb_t make_rgb(input int r, input int g, input int b);
    rgb_t v;
    v = '0;
    v.red   = OUT_BITS'(r);
    v.green = OUT_BITS'(g);
    v.blue  = OUT_BITS'(b);
    return v;
  endfunction

  function automatic void add_row(input logic reconf, input setup_t c, input pixel_t p,
                                  input logic typed, input rgb_t want);
    row_t r;
    r.reconf = reconf;
    r.setup  = c;
    r.pix    = p;
    r.typed  = typed;
    r.want   = want;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  function automatic sample_t rnd16();
    return sample_t'($urandom);
  endfunction

  // coordinate biased toward the frame edges and the ends of the field
  function automatic logic [COORD_BITS-1:0] pick_coord(input logic [DIM_BITS-1:0] dim);
    int d, v;
    d = (dim == 0) ? 1 : int'(dim);
    if (d > COORD_MAX + 1) d = COORD_MAX + 1;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = COORD_MAX;
      2: v = d - 2 + int'($urandom_range(0, 3));
      default: v = int'($urandom_range(0, d - 1));
    endcase
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_BITS'(v);
  endfunction

  // all six registers plus the two spare indexes; pattern writes carry junk above the code
  task automatic load_setup(input setup_t c);
    logic [REG_IDX_BITS-1:0] order [8];
    order = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_CFA_EE, REG_CFA_EO,
              REG_CFA_OE, REG_CFA_OO, REG_SPARE_LO, REG_SPARE_HI};
    foreach (order[i]) begin
      cfg_wr_en = 1'b1;
      cfg_index = order[i];
      case (order[i])
        REG_FRAME_WIDTH:  cfg_data = c.width;
        REG_FRAME_HEIGHT: cfg_data = c.height;
        REG_CFA_EE:       cfg_data = {(DIM_BITS - CODE_BITS)'($urandom), c.pattern[0]};
        REG_CFA_EO:       cfg_data = {(DIM_BITS - CODE_BITS)'($urandom), c.pattern[1]};
        REG_CFA_OE:       cfg_data = {(DIM_BITS - CODE_BITS)'($urandom), c.pattern[2]};
        REG_CFA_OO:       cfg_data = {(DIM_BITS - CODE_BITS)'($urandom), c.pattern[3]};
        default:          cfg_data = DIM_BITS'($urandom);
      endcase
      @(negedge clk);
    end
    cfg_wr_en = 1'b0;
    active = c;
  endtask

  // traffic knobs change right after a rising edge so the negedge processes agree on them
  task automatic set_traffic(input int send_pct, input int recv_pct, input logic hold);
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    hold_armed     = hold;
    @(negedge clk);
  endtask

  task automatic offer_pixel(input pixel_t pix, input rgb_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  = pix;
    next_want     = want;
    s_axis_tvalid = 1'b1;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid = 1'b0;
    while (rgb_expected.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off counted here when armed
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed) begin
        hold_left  = HOLD_CYCLES;
        hold_armed = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // both handshakes sampled at the rising edge
  always @(posedge clk) begin
    rgb_t got, want;
    logic out_took;
    if (rst) begin
      in_took      = 1'b0;
      quiet_cycles = 0;
    end else begin
      in_took  = s_axis_tvalid && s_axis_tready;
      out_took = m_axis_tvalid && m_axis_tready;
      if (in_took) rgb_expected.insert(rgb_expected.size(), next_want);
      if (out_took) begin
        got = m_axis_tdata;
        if (rgb_expected.size() == 0) begin
          $error("output transaction with nothing expected: %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = rgb_expected.pop_front();
          if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            fail_count++;
          end
          if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            fail_count++;
          end
          if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            fail_count++;
          end
        end
      end
      quiet_cycles = (in_took || out_took) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(negedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    setup_t rggb, c;
    pixel_t pix;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_FRAME_WIDTH;
    cfg_data      = '0;
    next_want     = '0;
    rggb   = make_setup(1920, 1080, CH_RED, CH_GREEN, CH_GREEN, CH_BLUE);
    active = rggb;

    // directed table, reset registers first
    add_row(1'b0, rggb, make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, make_rgb(0, 0, 0));
    add_row(1'b0, rggb, make_pixel(1, 1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
            16'hffff, 16'hffff, 16'hffff, 16'hffff), 1'b1, make_rgb(524280, 524280, 524280));
    add_row(1'b0, rggb, make_pixel(0, 0, 0, 0, 0, 0, 16'hffff, 0, 0, 0, 0),
            1'b1, make_rgb(524280, 0, 0));
    // centre far outside the frame: all neighbours dropped, blue centre kept
    add_row(1'b0, rggb, make_pixel(COORD_MAX, COORD_MAX, rnd16(), rnd16(), rnd16(), rnd16(),
            16'h1234, rnd16(), rnd16(), rnd16(), rnd16()), 1'b1, make_rgb(0, 0, 16'h1234 * 8));
    add_row(1'b0, rggb, make_pixel(1919, 1079, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
            rnd16(), rnd16(), rnd16(), rnd16()), 1'b0, '0);
    add_row(1'b0, rggb, make_pixel(0, 1079, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
            rnd16(), rnd16(), rnd16(), rnd16()), 1'b0, '0);
    add_row(1'b0, rggb, make_pixel(1919, 0, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
            rnd16(), rnd16(), rnd16(), rnd16()), 1'b0, '0);
    for (int k = 0; k < 4; k++) begin
      add_row(1'b0, rggb, make_pixel(100 + k % 2, 200 + k / 2, rnd16(), rnd16(), rnd16(),
              rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16()), 1'b0, '0);
    end
    // small sums where the rounding shows
    add_row(1'b0, rggb, make_pixel(1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, rggb, make_pixel(1, 0, 0, 0, 0, 1, 7, 2, 0, 5, 0), 1'b0, '0);
    // zero frame size: nothing to average
    c = make_setup(0, 0, CH_RED, CH_GREEN, CH_GREEN, CH_BLUE);
    add_row(1'b1, c, make_pixel(0, 0, rnd16(), rnd16(), rnd16(), rnd16(), 16'hffff,
            rnd16(), rnd16(), rnd16(), rnd16()), 1'b1, make_rgb(524280, 0, 0));
    add_row(1'b0, c, make_pixel(2, 3, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
            rnd16(), rnd16(), rnd16(), rnd16()), 1'b0, '0);
    // every site without a channel
    c = make_setup(1920, 1080, CH_NONE, CH_NONE, CH_NONE, CH_NONE);
    add_row(1'b1, c, make_pixel(5, 5, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
            16'hffff, 16'hffff, 16'hffff, 16'hffff), 1'b1, make_rgb(0, 0, 0));
    // widest frame, all-ones register value, neighbours past column 4095 still in frame
    c = make_setup(8191, 8191, CH_BLUE, CH_GREEN, CH_GREEN, CH_RED);
    add_row(1'b1, c, make_pixel(COORD_MAX, COORD_MAX, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
            16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b1,
            make_rgb(262144, 262144, 262144));
    c = make_setup(1, 1, CH_RED, CH_GREEN, CH_GREEN, CH_BLUE);
    add_row(1'b1, c, make_pixel(0, 0, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
            rnd16(), rnd16(), rnd16(), rnd16()), 1'b0, '0);
    add_row(1'b0, c, make_pixel(1, 0, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
            rnd16(), rnd16(), rnd16(), rnd16()), 1'b0, '0);
    c = make_setup(3, 3, CH_NONE, CH_RED, CH_BLUE, CH_GREEN);
    add_row(1'b1, c, make_pixel(1, 1, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
            rnd16(), rnd16(), rnd16(), rnd16()), 1'b0, '0);

    repeat (5) @(negedge clk);
    rst = 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].reconf) begin
        drain_pipeline();
        load_setup(stim_rows[i].setup);
      end
      offer_pixel(stim_rows[i].pix, stim_rows[i].typed ? stim_rows[i].want :
                  demosaic_rgb(stim_rows[i].pix, active));
    end

    // random phases, each under its own pattern, frame size and traffic
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_pipeline();
      case (ph)
        0: c = rggb;
        1: c = make_setup(1, 1, CH_GREEN, CH_RED, CH_BLUE, CH_GREEN);
        2: c = make_setup(4096, 4096, CH_BLUE, CH_GREEN, CH_GREEN, CH_RED);
        3: c = make_setup(0, 0, CH_GREEN, CH_BLUE, CH_RED, CH_GREEN);
        4: c = make_setup(8191, 8191, CODE_BITS'($urandom), CODE_BITS'($urandom),
                          CODE_BITS'($urandom), CODE_BITS'($urandom));
        5: c = make_setup(2, 3, CODE_BITS'($urandom), CODE_BITS'($urandom),
                          CODE_BITS'($urandom), CODE_BITS'($urandom));
        6: c = make_setup($urandom_range(1, 16), $urandom_range(1, 16), CODE_BITS'($urandom),
                          CODE_BITS'($urandom), CODE_BITS'($urandom), CODE_BITS'($urandom));
        default: c = make_setup($urandom_range(1, 4096), $urandom_range(1, 4096),
                                CODE_BITS'($urandom), CODE_BITS'($urandom),
                                CODE_BITS'($urandom), CODE_BITS'($urandom));
      endcase
      load_setup(c);
      // first phase: no idling, but the output is held off long enough to back up the input
      case (ph % 4)
        0: set_traffic(0, 0, ph == 0);
        1: set_traffic(58, 0, 1'b0);
        2: set_traffic(0, 58, 1'b0);
        default: set_traffic(33, 33, 1'b0);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pix = IN_BYTES_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        pix.pos_x = pick_coord(active.width);
        pix.pos_y = pick_coord(active.height);
        // now and then a window of rail values only
        if ($urandom_range(0, 7) == 0) begin
          for (int k = 0; k < 9; k++) begin
            pix[2 * COORD_BITS + SAMPLE_BITS * k +: SAMPLE_BITS] =
              {SAMPLE_BITS{1'($urandom_range(0, 1))}};
          end
        end
        offer_pixel(pix, demosaic_rgb(pix, active));
      end
    end

    drain_pipeline();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
